// ----- rtl/core/pptr_pkg.sv -----
// package for the pre/post trigger transition recorder
// types, function codes and constants shared by pptr_front, pptr_back, the top and the checker
package pptr_pkg;
  localparam logic [2:0] FUNC_SAMPLE  = 3'd0;
  localparam logic [2:0] FUNC_FREEZE  = 3'd1;
  localparam logic [2:0] FUNC_SEAL    = 3'd2;
  localparam logic [2:0] FUNC_READ    = 3'd3;
  localparam logic [2:0] FUNC_RELEASE = 3'd4;
  localparam logic [2:0] FUNC_STAT    = 3'd5;

  localparam logic [7:0] STAT_LAPS    = 8'd0;
  localparam logic [7:0] STAT_SKIPPED = 8'd1;
  localparam logic [7:0] STAT_FROZEN  = 8'd2;

  localparam logic [1:0] LEVEL_MASK = 2'h3;
  localparam logic [15:0] SKIP_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  line_level;
    logic [31:0] tick_stamp;
    logic [7:0]  capture_tag;
    logic [7:0]  item_index;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic        capture_ready;
    logic [8:0]  captured_count;
    logic [7:0]  trigger_position;
    logic [7:0]  capture_label;
    logic [7:0]  capture_session;
    logic        capture_partial;
    logic [31:0] event_tick;
    logic [15:0] event_sequence;
    logic [5:0]  event_transition;
    logic [7:0]  event_label;
    logic [31:0] stat_value;
  } out_item_t;
endpackage

// ----- rtl/core/pptr_if.sv -----
// valid/ready channel interface carrying one payload type
// depends on nothing; payload type given by parameter
interface pptr_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/pptr_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module pptr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/pptr_front.sv -----
// front part: queues accepted items and hands them to the back part
// depends on pptr_pkg
module pptr_front import pptr_pkg::*; #(
  parameter int QDEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_pop,
  output in_item_t q_data
);
  localparam int AW = $clog2(QDEPTH);
  in_item_t      fifo_r [QDEPTH];
  logic [AW-1:0] rd_r, wr_r;
  logic [AW:0]   cnt_r;
  logic          push;

  assign in_ready = (cnt_r < (AW+1)'(QDEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != '0);
  assign q_data = fifo_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_r] <= in_data;
    if (!rst_n) begin
      rd_r <= '0;
      wr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == AW'(QDEPTH-1)) ? '0 : wr_r + 1'b1;
      if (q_pop) rd_r <= (rd_r == AW'(QDEPTH-1)) ? '0 : rd_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end
endmodule

// ----- rtl/core/pptr_back.sv -----
// back part: history ring, capture store, freeze copy sequencer, result register
// depends on pptr_pkg and pptr_ram
module pptr_back import pptr_pkg::*; #(
  parameter int RING_DEPTH = 256,
  parameter int STORE_DEPTH = 256,
  parameter int PRE_WINDOW = 128,
  parameter int POST_WINDOW = 128,
  parameter logic [7:0] NO_CAPTURE_CODE = 8'd255
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [7:0] session_number,
  input  logic      q_valid,
  output logic      q_pop,
  input  in_item_t  q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  localparam int RW = $clog2(RING_DEPTH);
  localparam int SW = $clog2(STORE_DEPTH);
  localparam int RC = $clog2(RING_DEPTH + 1);
  localparam int SC = $clog2(STORE_DEPTH + 1);
  localparam int PRE_EFF = (PRE_WINDOW < STORE_DEPTH) ? PRE_WINDOW : STORE_DEPTH;
  localparam logic [1:0] PH_FREE = 2'd0, PH_FILL = 2'd1, PH_READY = 2'd2;
  localparam logic [1:0] ST_RUN = 2'd0, ST_COPY = 2'd1, ST_READ = 2'd2;

  logic [1:0]    st_r, st_nxt;
  logic [RW-1:0] wptr_r;
  logic [RC-1:0] rcount_r;
  logic [15:0]   evcnt_r, skip_r;
  logic [31:0]   laps_r, frozen_r;
  logic [1:0]    phase_r, prev_r;
  logic          seen_r, partial_r;
  logic [SC-1:0] fill_r, limit_r, pre_r;
  logic [7:0]    trig_r, label_r, sess_r;
  logic [SC-1:0] ci_r;
  logic          cvalid_r;
  logic [RW-1:0] csrc_r;
  logic          rdok_r;
  logic          out_valid_nxt;
  out_item_t     res_r, res_nxt;

  logic          ring_we, store_we;
  logic [RW-1:0] ring_raddr;
  logic [SW-1:0] store_waddr, store_raddr;
  logic [55:0]   ring_wdata, ring_rdata;
  logic [63:0]   store_wdata, store_rdata;

  pptr_ram #(.WIDTH(56), .DEPTH(RING_DEPTH)) u_ring (
    .clk, .we(ring_we), .waddr(wptr_r), .wdata(ring_wdata),
    .raddr(ring_raddr), .rdata(ring_rdata));
  pptr_ram #(.WIDTH(64), .DEPTH(STORE_DEPTH)) u_store (
    .clk, .we(store_we), .waddr(store_waddr), .wdata(store_wdata),
    .raddr(store_raddr), .rdata(store_rdata));

  logic out_free, can_out, is_change, fire_log, do_freeze;
  logic [5:0] code;
  logic [SC-1:0] pre_c, lim_c;
  logic [SC+11:0] lim_sum;
  logic [RW:0] src_start;
  logic [RW-1:0] src_wrap;

  assign out_free = !out_valid || out_ready;
  assign can_out  = q_valid && (st_r == ST_RUN) && out_free;
  assign code = {prev_r, 2'b00, q_data.line_level};
  assign is_change = seen_r && (q_data.line_level != prev_r);
  assign fire_log = can_out && (q_data.func == FUNC_SAMPLE) && is_change;
  assign do_freeze = can_out && (q_data.func == FUNC_FREEZE) && (phase_r == PH_FREE)
                     && (rcount_r != '0);

  always_comb begin
    if (32'(rcount_r) > PRE_EFF) pre_c = SC'(PRE_EFF);
    else pre_c = SC'(rcount_r);
    lim_sum = (SC+12)'(pre_c) + (SC+12)'(POST_WINDOW);
    if (lim_sum > (SC+12)'(STORE_DEPTH)) lim_c = SC'(STORE_DEPTH);
    else lim_c = SC'(lim_sum);
    src_start = {1'b0, wptr_r} + (RW+1)'(RING_DEPTH) - (RW+1)'(pre_c);
    if (src_start >= (RW+1)'(RING_DEPTH)) src_wrap = RW'(src_start - (RW+1)'(RING_DEPTH));
    else src_wrap = RW'(src_start);
  end

  assign ring_we = fire_log;
  assign ring_wdata = {q_data.tick_stamp, evcnt_r, 2'b00, code};
  assign ring_raddr = csrc_r;

  always_comb begin
    store_we = 1'b0;
    store_waddr = SW'(fill_r);
    store_wdata = {q_data.tick_stamp, evcnt_r, 2'b00, code, label_r};
    if (st_r == ST_COPY && cvalid_r) begin
      store_we = 1'b1;
      store_waddr = SW'(ci_r - 1'b1);
      store_wdata = {ring_rdata, label_r};
    end else if (fire_log && phase_r == PH_FILL && fill_r < SC'(STORE_DEPTH)) begin
      store_we = 1'b1;
    end
  end
  assign store_raddr = SW'(q_data.item_index);

  assign q_pop = (can_out && !(q_data.func == FUNC_READ)) || (st_r == ST_READ && out_free);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_RUN: begin
        if (do_freeze) st_nxt = ST_COPY;
        else if (can_out && q_data.func == FUNC_READ) st_nxt = ST_READ;
      end
      ST_COPY: if (cvalid_r && ci_r == pre_r) st_nxt = ST_RUN;
      ST_READ: if (out_free) st_nxt = ST_RUN;
      default: st_nxt = ST_RUN;
    endcase
  end

  logic rd_ok;
  assign rd_ok = (phase_r == PH_READY) && (SC'(q_data.item_index) < fill_r)
                 && (32'(q_data.item_index) < STORE_DEPTH);

  always_comb begin
    out_valid_nxt = out_valid && !out_ready;
    res_nxt = res_r;
    if (st_r == ST_READ && out_free) begin
      out_valid_nxt = 1'b1;
      res_nxt = '0;
      res_nxt.ok = rdok_r;
      if (rdok_r) begin
        res_nxt.event_tick = store_rdata[63:32];
        res_nxt.event_sequence = store_rdata[31:16];
        res_nxt.event_transition = store_rdata[13:8];
        res_nxt.event_label = store_rdata[7:0];
      end
    end
    if (can_out) begin
      out_valid_nxt = (q_data.func != FUNC_READ);
      res_nxt = '0;
      case (q_data.func)
        FUNC_SAMPLE: res_nxt.ok = is_change;
        FUNC_FREEZE: res_nxt.ok = do_freeze;
        FUNC_STAT: begin
          case (q_data.item_index)
            STAT_LAPS: begin res_nxt.ok = 1'b1; res_nxt.stat_value = laps_r; end
            STAT_SKIPPED: begin
              res_nxt.ok = 1'b1;
              res_nxt.stat_value = {16'd0, skip_r};
            end
            STAT_FROZEN: begin res_nxt.ok = 1'b1; res_nxt.stat_value = frozen_r; end
            default: res_nxt.ok = 1'b0;
          endcase
        end
        default: res_nxt.ok = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RUN;
      wptr_r <= '0; rcount_r <= '0; evcnt_r <= '0; laps_r <= '0;
      phase_r <= PH_FREE; fill_r <= '0; limit_r <= SC'(STORE_DEPTH);
      trig_r <= '0; label_r <= NO_CAPTURE_CODE; sess_r <= '0; partial_r <= 1'b0;
      skip_r <= '0; prev_r <= '0; seen_r <= 1'b0; frozen_r <= '0;
      out_valid <= 1'b0; cvalid_r <= 1'b0; ci_r <= '0; pre_r <= '0; csrc_r <= '0;
      rdok_r <= 1'b0; res_r <= '0;
    end else begin
      st_r <= st_nxt;
      out_valid <= out_valid_nxt;
      res_r <= res_nxt;
      if (can_out && q_data.func == FUNC_READ) rdok_r <= rd_ok;
      if (st_r == ST_COPY) begin
        if (ci_r != pre_r) begin
          ci_r <= ci_r + 1'b1;
          csrc_r <= (csrc_r == RW'(RING_DEPTH-1)) ? '0 : csrc_r + 1'b1;
        end
        cvalid_r <= !(cvalid_r && ci_r == pre_r);
      end
      if (do_freeze) begin
        label_r <= q_data.capture_tag;
        sess_r <= session_number;
        partial_r <= 1'b0;
        trig_r <= 8'(pre_c - 1'b1);
        fill_r <= pre_c;
        limit_r <= lim_c;
        pre_r <= pre_c;
        ci_r <= '0;
        cvalid_r <= 1'b0;
        csrc_r <= src_wrap;
        if (pre_c >= lim_c) begin
          phase_r <= PH_READY;
          frozen_r <= frozen_r + 1'b1;
        end else phase_r <= PH_FILL;
      end
      if (can_out) begin
        case (q_data.func)
          FUNC_SAMPLE: begin
            if (!seen_r) begin
              seen_r <= 1'b1;
              prev_r <= q_data.line_level;
            end else if (is_change) begin
              prev_r <= q_data.line_level;
              wptr_r <= (wptr_r == RW'(RING_DEPTH-1)) ? '0 : wptr_r + 1'b1;
              if (rcount_r < RC'(RING_DEPTH)) rcount_r <= rcount_r + 1'b1;
              else if (wptr_r == RW'(RING_DEPTH-1)) laps_r <= laps_r + 1'b1;
              evcnt_r <= evcnt_r + 1'b1;
              if (phase_r == PH_FILL && fill_r < SC'(STORE_DEPTH)) begin
                fill_r <= fill_r + 1'b1;
                if (fill_r + 1'b1 >= limit_r) begin
                  phase_r <= PH_READY;
                  frozen_r <= frozen_r + 1'b1;
                end
              end
            end
          end
          FUNC_FREEZE: begin
            if (phase_r != PH_FREE && skip_r != SKIP_MAX) skip_r <= skip_r + 1'b1;
          end
          FUNC_SEAL: begin
            if (phase_r == PH_FILL) begin
              partial_r <= 1'b1;
              phase_r <= PH_READY;
              frozen_r <= frozen_r + 1'b1;
            end
          end
          FUNC_RELEASE: begin
            if (phase_r == PH_READY) begin
              fill_r <= '0;
              limit_r <= SC'(STORE_DEPTH);
              trig_r <= '0;
              label_r <= NO_CAPTURE_CODE;
              partial_r <= 1'b0;
              phase_r <= PH_FREE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // capture status reflects state after the item, valid while result is held
  logic rdy;
  assign rdy = (phase_r == PH_READY);
  always_comb begin
    out_data = res_r;
    out_data.capture_ready = rdy;
    out_data.captured_count = rdy ? 9'(fill_r) : '0;
    out_data.trigger_position = rdy ? trig_r : '0;
    out_data.capture_label = rdy ? label_r : NO_CAPTURE_CODE;
    out_data.capture_session = rdy ? sess_r : '0;
    out_data.capture_partial = rdy && partial_r;
  end
endmodule

// ----- rtl/core/pre_post_trigger_transition_recorder.sv -----
// top level of the pre/post trigger transition recorder
// results are registered in the back part; an entry read passes through a read state
// throughput: 1 transaction per cycle for samples, seals, releases, statistics,
// unless out_ready stalls; a freeze holds the back part while the pre part is copied
// reset: synchronous active-low rst_n clears all control state; memories are not cleared
// depends on pptr_pkg, pptr_if, pptr_ram, pptr_front, pptr_back
module pre_post_trigger_transition_recorder import pptr_pkg::*; #(
  parameter int RING_DEPTH = 256,
  parameter int STORE_DEPTH = 256,
  parameter int PRE_WINDOW = 128,
  parameter int POST_WINDOW = 128,
  parameter logic [7:0] NO_CAPTURE_CODE = 8'd255
) (
  input  logic       clk,
  input  logic       rst_n,
  pptr_if.sink       in_ch,
  pptr_if.source     out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  logic [7:0] session_r;
  logic       q_valid, q_pop;
  in_item_t   q_data;
  out_item_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) session_r <= '0;
    else if (cfg_we) session_r <= cfg_wdata;
  end

  pptr_front #(.QDEPTH(2)) u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid, .q_pop, .q_data);

  pptr_back #(
    .RING_DEPTH(RING_DEPTH), .STORE_DEPTH(STORE_DEPTH), .PRE_WINDOW(PRE_WINDOW),
    .POST_WINDOW(POST_WINDOW), .NO_CAPTURE_CODE(NO_CAPTURE_CODE)
  ) u_back (
    .clk, .rst_n, .session_number(session_r), .q_valid, .q_pop, .q_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(res));

  assign out_ch.data = res;
endmodule

// ----- rtl/core/pptr_checker.sv -----
// port-level checker for the recorder, bound to the top level
// depends on pptr_pkg
module pptr_props import pptr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");
  a_rdy_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.capture_ready |-> out_data.captured_count == 9'd0)
    else $error("count shown without ready capture");
  a_partial: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.capture_partial |-> out_data.capture_ready)
    else $error("partial flag without ready capture");
  a_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.event_tick == 32'd0 && out_data.stat_value == 32'd0)
    else $error("payload without ok");
endmodule

bind pre_post_trigger_transition_recorder pptr_props u_chk (
  .clk, .rst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
